>>> rtl/full_linear_convolution_unit_defines.svh
// Assertion macros shared by the convolution unit checker.
`ifndef FULL_LINEAR_CONVOLUTION_UNIT_DEFINES_SVH
`define FULL_LINEAR_CONVOLUTION_UNIT_DEFINES_SVH

// The consequent must hold in the clock after the antecedent.
`define FLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the same clock as the antecedent.
`define FLC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/flcu_pkg.sv
// Package with sizes, request codes and control types of the convolution unit.
package flcu_pkg;

    localparam int MAX_TAPS  = 16;
    localparam int TAP_IDX_W = $clog2(MAX_TAPS);
    localparam int CNT_W     = $clog2(MAX_TAPS + 1);
    localparam int SAMPLE_W  = 16;
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int ACC_W     = 40;

    localparam logic ACT_TAP    = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic                 tap_wr;
        logic [TAP_IDX_W-1:0] tap_addr;
        logic                 shift_en;
        logic                 shift_zero;
        logic                 clear_dly;
        logic                 mac_issue;
        logic [TAP_IDX_W-1:0] mac_idx;
        logic                 mac_first;
        logic                 mac_last;
        logic                 out_load;
        logic                 out_zero;
        logic                 out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic acc_done;
        logic out_free;
    } t_dp_stat;

endpackage

>>> rtl/flc_ctrl.sv
// Controller state machine: kernel bookkeeping, tap sequencing and tail flush.
module flc_ctrl import flcu_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    input  logic     i_req_action,
    input  logic     i_req_last,
    output logic     o_req_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SUM   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_PUSH  = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [CNT_W-1:0]     r_tap_total, n_tap_total;
    logic                 r_closed, n_closed;
    logic                 r_last, n_last;
    logic                 r_zero, n_zero;
    logic [CNT_W-1:0]     r_tail, n_tail;
    logic [TAP_IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0]     w_total_m1;
    logic [TAP_IDX_W-1:0] w_top;
    logic                 w_end;

    assign o_req_ready = (r_state == ST_IDLE);
    assign w_total_m1  = r_tap_total - 1'b1;
    assign w_top       = w_total_m1[TAP_IDX_W-1:0];
    assign w_end       = (r_idx == w_top);

    always_comb begin
        n_state     = r_state;
        n_tap_total = r_tap_total;
        n_closed    = r_closed;
        n_last      = r_last;
        n_zero      = r_zero;
        n_tail      = r_tail;
        n_idx       = r_idx;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    if (i_req_action == ACT_TAP) begin
                        if (r_closed) begin
                            // A tap after a finished kernel starts a new one.
                            o_cmd.tap_wr   = 1'b1;
                            o_cmd.tap_addr = '0;
                            n_tap_total    = CNT_W'(1);
                            n_closed       = 1'b0;
                        end else if (r_tap_total < CNT_W'(MAX_TAPS)) begin
                            o_cmd.tap_wr   = 1'b1;
                            o_cmd.tap_addr = r_tap_total[TAP_IDX_W-1:0];
                            n_tap_total    = r_tap_total + 1'b1;
                        end
                        if (i_req_last) begin
                            n_closed        = 1'b1;
                            o_cmd.clear_dly = 1'b1;
                        end
                    end else begin
                        o_cmd.shift_en = 1'b1;
                        n_last         = i_req_last;
                        n_idx          = '0;
                        if (!r_closed || (r_tap_total == '0)) begin
                            n_zero  = 1'b1;
                            n_tail  = '0;
                            n_state = ST_PUSH;
                        end else begin
                            n_zero  = 1'b0;
                            n_tail  = i_req_last ? w_total_m1 : '0;
                            n_state = ST_SUM;
                        end
                    end
                end
            end
            ST_SUM: begin
                o_cmd.mac_issue = 1'b1;
                o_cmd.mac_idx   = r_idx;
                o_cmd.mac_first = (r_idx == '0);
                o_cmd.mac_last  = w_end;
                if (w_end) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (i_stat.acc_done) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_zero = r_zero;
                    o_cmd.out_last = r_last && (r_tail == '0);
                    if (r_tail != '0) begin
                        o_cmd.shift_en   = 1'b1;
                        o_cmd.shift_zero = 1'b1;
                        n_tail           = r_tail - 1'b1;
                        n_idx            = '0;
                        n_state          = ST_SUM;
                    end else begin
                        o_cmd.clear_dly = r_last;
                        n_state         = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tap_total <= '0;
            r_closed    <= 1'b1;
            r_last      <= 1'b0;
            r_zero      <= 1'b0;
            r_tail      <= '0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_tap_total <= n_tap_total;
            r_closed    <= n_closed;
            r_last      <= n_last;
            r_zero      <= n_zero;
            r_tail      <= n_tail;
            r_idx       <= n_idx;
        end
    end

endmodule

>>> rtl/flc_datapath.sv
// Datapath: tap memory, delay line, multiply-accumulate pipeline and output register.
module flc_datapath import flcu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_sample          i_item_value,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [ACC_W-1:0] o_out_value,
    output logic             o_out_last
);

    t_sample                  r_tap_mem [MAX_TAPS];
    t_sample                  r_dly [MAX_TAPS];
    t_sample                  r_tap_q, r_dly_q;
    logic                     r_v1, r_f1, r_l1;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_v2, r_f2, r_l2;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_done;
    logic                     r_out_valid;
    logic [ACC_W-1:0]         r_out_value;
    logic                     r_out_last;
    t_sample                  w_shift_val;
    logic signed [ACC_W-1:0]  w_prod_ext;

    assign w_shift_val = i_cmd.shift_zero ? '0 : i_item_value;
    assign w_prod_ext  = {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};

    // Tap memory, read one tap per cycle during a sum.
    always_ff @(posedge i_clk) begin
        if (i_cmd.tap_wr) begin
            r_tap_mem[i_cmd.tap_addr] <= i_item_value;
        end
        if (i_cmd.mac_issue) begin
            r_tap_q <= r_tap_mem[i_cmd.mac_idx];
            r_dly_q <= r_dly[i_cmd.mac_idx];
        end
    end

    // Delay line, newest sample at index zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_dly) begin
            for (int i = 0; i < MAX_TAPS; i++) begin
                r_dly[i] <= '0;
            end
        end else if (i_cmd.shift_en) begin
            for (int i = MAX_TAPS - 1; i > 0; i--) begin
                r_dly[i] <= r_dly[i-1];
            end
            r_dly[0] <= w_shift_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_tap_q * r_dly_q;
        if (r_v2) begin
            r_acc <= (r_f2 ? '0 : r_acc) + w_prod_ext;
        end
        if (i_cmd.out_load) begin
            r_out_value <= i_cmd.out_zero ? '0 : r_acc;
            r_out_last  <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_f1        <= 1'b0;
            r_l1        <= 1'b0;
            r_v2        <= 1'b0;
            r_f2        <= 1'b0;
            r_l2        <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= i_cmd.mac_issue;
            r_f1 <= i_cmd.mac_first;
            r_l1 <= i_cmd.mac_last;
            r_v2 <= r_v1;
            r_f2 <= r_f1;
            r_l2 <= r_l1;
            if (r_v2 && r_l2) begin
                r_done <= 1'b1;
            end else if (i_cmd.mac_issue && i_cmd.mac_first) begin
                r_done <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.acc_done = r_done;
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_value     = r_out_value;
    assign o_out_last      = r_out_last;

endmodule

>>> rtl/full_linear_convolution_unit.sv
// Top level of the full linear convolution unit, a streaming FIR filter.
//
// Channel    Direction  Payload                                   Marker
// s_axis     in         tdata[15:0] item_value (Q1.15)            tuser action, tlast last_item
// m_axis     out        tdata[39:0] result_value (Q10.30)         tlast last_result
//
// A tap request leaves the block idle, so it is ready again in the next cycle.
// A sample request with a closed kernel of K taps issues its taps in the sum state, waits
// in the drain state for the last accumulate and then loads the output, as does each tail
// output: the single shared multiply-accumulate pipeline (memory read, multiply,
// accumulate) handles one tap per cycle. A sample without a closed kernel returns zero.
// Reset is synchronous and active low; it clears the delay line and the kernel state.
// A stalled output holds its result while the block is already free to take requests.
module full_linear_convolution_unit import flcu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [15:0]      i_s_axis_tdata,   // [15:0] item_value
    input  logic             i_s_axis_tuser,   // [0] action: tap or sample
    input  logic             i_s_axis_tlast,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [ACC_W-1:0] o_m_axis_tdata,   // [39:0] result_value
    output logic             o_m_axis_tlast
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // The controller decides what each request does; the datapath only executes.
    flc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_s_axis_tvalid),
        .i_req_action (i_s_axis_tuser),
        .i_req_last   (i_s_axis_tlast),
        .o_req_ready  (o_s_axis_tready),
        .o_cmd        (w_cmd),
        .i_stat       (w_stat)
    );

    // The datapath owns the taps, the delay line and the output register.
    flc_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_value (t_sample'(i_s_axis_tdata)),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_out_value  (o_m_axis_tdata),
        .o_out_last   (o_m_axis_tlast)
    );

endmodule

>>> rtl/flc_checker.sv
// Port-level checker for the convolution unit and its bind statement.
`include "full_linear_convolution_unit_defines.svh"

module flc_checker import flcu_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_axis_tvalid,
    input logic             o_s_axis_tready,
    input logic             i_s_axis_tuser,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [ACC_W-1:0] o_m_axis_tdata,
    input logic             o_m_axis_tlast
);

    logic w_in_acc;

    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // A result held back by the sink keeps its value.
    `FLC_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast),
        "stalled result changed")

    // After a tap request the block is ready again in the next cycle.
    `FLC_ASSERT_NEXT(a_tap_fast, w_in_acc && (i_s_axis_tuser == ACT_TAP),
        o_s_axis_tready, "not ready after tap request")

    // After a sample request the block is not ready in the next cycle.
    `FLC_ASSERT_NEXT(a_sample_busy, w_in_acc && (i_s_axis_tuser == ACT_SAMPLE),
        !o_s_axis_tready, "ready right after sample request")

    // A tap request accepted while no result is offered does not raise a result.
    `FLC_ASSERT_NEXT(a_tap_silent,
        w_in_acc && (i_s_axis_tuser == ACT_TAP) && !o_m_axis_tvalid,
        !o_m_axis_tvalid, "result after tap request")

    // No result is offered in the first cycle after reset is released.
    `FLC_ASSERT_NOW(a_reset_quiet, !$past(i_rst_n), !o_m_axis_tvalid,
        "result valid right after reset")

endmodule

bind full_linear_convolution_unit flc_checker u_flc_checker (.*);

>>> tb/full_linear_convolution_unit_tb.sv
// Self-checking testbench of the full linear convolution unit: directed table, then random traffic.
`timescale 1ns / 100ps

module full_linear_convolution_unit_tb;
    import flcu_pkg::*;

    localparam int RANDOM_ITEMS   = 150;
    localparam int HOLD_OFF_AFTER = 40;     // results seen before the long output stall
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 400;    // longer than a full 16-tap tail
    localparam int TIMEOUT_NS     = 10_000_000;

    typedef struct {
        logic signed [ACC_W-1:0] sum;
        logic                    is_last;
    } t_conv_result;

    // One row of the directed table. Rows with pinned set carry the result that the
    // block must return; all other rows are checked against the predictor.
    typedef struct {
        logic                    action;
        t_sample                 value;
        logic                    last;
        int unsigned             reps;
        bit                      pinned;
        logic signed [ACC_W-1:0] sum;
        logic                    is_last;
    } t_directed_row;

    localparam int N_DIRECTED = 11;

    logic             i_clk           = 1'b0;
    logic             i_rst_n         = 1'b0;
    logic             i_s_axis_tvalid = 1'b0;
    logic             o_s_axis_tready;
    logic [15:0]      i_s_axis_tdata  = '0;     // [15:0] item_value
    logic             i_s_axis_tuser  = 1'b0;   // [0] action
    logic             i_s_axis_tlast  = 1'b0;   // last tap or last sample
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready = 1'b0;
    logic [ACC_W-1:0] o_m_axis_tdata;           // [39:0] result_value
    logic             o_m_axis_tlast;           // final output of the convolution

    // Predictor state: kernel taps, delay line (newest first), tap count, kernel closed.
    t_sample      kernel_taps [MAX_TAPS] = '{default: '0};
    t_sample      sample_history [MAX_TAPS] = '{default: '0};
    int unsigned  kernel_len    = 0;
    bit           kernel_sealed = 1'b1;

    t_conv_result fresh_results [$];
    t_conv_result expected_results [$];
    t_conv_result due_result;
    int unsigned  mismatch_count = 0;
    int unsigned  results_seen   = 0;
    int unsigned  items_sent     = 0;

    t_directed_row directed_rows [N_DIRECTED] = '{
        // Sample right after reset: no kernel yet, so a zero that keeps the last mark.
        '{ACT_SAMPLE, -16'sd7,     1'b1, 1,  1'b1, '0,                1'b1},
        // One-tap kernel at the negative extreme.
        '{ACT_TAP,    16'sh8000,   1'b1, 1,  1'b0, '0,                1'b0},
        '{ACT_SAMPLE, 16'sh7FFF,   1'b0, 1,  1'b1, -40'sd1073709056,  1'b0},
        '{ACT_SAMPLE, 16'sh8000,   1'b1, 1,  1'b1, 40'sd1073741824,   1'b1},
        // A new kernel is opened; a sample while it is still open returns zero.
        '{ACT_TAP,    16'sd100,    1'b0, 1,  1'b0, '0,                1'b0},
        '{ACT_SAMPLE, 16'sd1234,   1'b0, 1,  1'b1, '0,                1'b0},
        '{ACT_TAP,    16'sd200,    1'b1, 1,  1'b0, '0,                1'b0},
        '{ACT_SAMPLE, 16'sd2,      1'b1, 1,  1'b0, '0,                1'b0},
        // Full kernel, then one tap too many that is dropped but still closes it.
        '{ACT_TAP,    16'sh8000,   1'b0, 16, 1'b0, '0,                1'b0},
        '{ACT_TAP,    16'sh7FFF,   1'b1, 1,  1'b0, '0,                1'b0},
        '{ACT_SAMPLE, 16'sh8000,   1'b1, 1,  1'b0, '0,                1'b0}
    };

    full_linear_convolution_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int idle_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random Q1.15 value with the extremes, zero and minus one drawn more often.
    function automatic t_sample random_q15();
        case ($urandom_range(0, 11))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            3: return -16'sd1;
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic void clear_history();
        for (int k = 0; k < MAX_TAPS; k++) sample_history[k] = '0;
    endfunction

    function automatic void shift_history(t_sample sample);
        for (int k = MAX_TAPS - 1; k > 0; k--) sample_history[k] = sample_history[k-1];
        sample_history[0] = sample;
    endfunction

    // Sum of tap times delayed sample over the loaded taps, exact in 40 bits.
    function automatic logic signed [ACC_W-1:0] fir_output();
        logic signed [ACC_W-1:0]  acc;
        logic signed [PROD_W-1:0] prod;
        acc = '0;
        for (int k = 0; k < kernel_len; k++) begin
            prod = kernel_taps[k] * sample_history[k];
            acc  = acc + prod;
        end
        return acc;
    endfunction

    // Advances the predictor by one accepted request and leaves its results in fresh_results.
    function automatic void convolve_request(logic action, t_sample value, logic last);
        t_conv_result res;
        fresh_results.delete();
        if (action == ACT_TAP) begin
            // A tap after a closed kernel starts loading a new one.
            if (kernel_sealed) begin
                kernel_len    = 0;
                kernel_sealed = 1'b0;
            end
            if (kernel_len < MAX_TAPS) begin
                kernel_taps[kernel_len] = value;
                kernel_len++;
            end
            if (last) begin
                kernel_sealed = 1'b1;
                clear_history();
            end
            return;
        end
        shift_history(value);
        if (!kernel_sealed || kernel_len == 0) begin
            res.sum     = '0;
            res.is_last = last;
            fresh_results.push_back(res);
            if (last) clear_history();
            return;
        end
        res.sum     = fir_output();
        res.is_last = last && (kernel_len == 1);
        fresh_results.push_back(res);
        if (last) begin
            // The tail flushes the delay line with zeros, one output per extra tap.
            for (int t = 1; t < kernel_len; t++) begin
                shift_history('0);
                res.sum     = fir_output();
                res.is_last = (t == kernel_len - 1);
                fresh_results.push_back(res);
            end
            clear_history();
        end
    endfunction

    // Offers one request at falling edges, waits for its acceptance and books its results.
    task automatic issue_item(input logic action, input t_sample value, input logic last,
                              input bit tight, input bit pinned,
                              input logic signed [ACC_W-1:0] pinned_sum,
                              input logic pinned_last);
        int           gap;
        t_conv_result res;
        gap = tight ? 0 : idle_length();
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = value;
        i_s_axis_tuser  = action;
        i_s_axis_tlast  = last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        items_sent++;
        convolve_request(action, value, last);
        if (pinned) begin
            res.sum     = pinned_sum;
            res.is_last = pinned_last;
            expected_results.push_back(res);
        end else begin
            while (fresh_results.size() > 0) expected_results.push_back(fresh_results.pop_front());
        end
    endtask

    function automatic int unsigned kernel_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return $urandom_range(1, 5);
        if (roll < 90) return $urandom_range(6, MAX_TAPS);
        return $urandom_range(MAX_TAPS + 1, MAX_TAPS + 3);
    endfunction

    // Mostly complete kernels followed by complete signals with random content; the rest
    // reuses the kernel, breaks off a kernel load, or is plain noise.
    task automatic run_random_traffic();
        int unsigned start_count;
        int unsigned shape;
        int unsigned taps;
        int unsigned signals;
        int unsigned samples;
        int unsigned k;
        int unsigned s;
        bit          tight;
        bit          close_signal;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            shape = $urandom_range(0, 99);
            tight = ($urandom_range(0, 3) == 0);
            if (shape < 80) begin
                if (shape < 68) begin
                    taps = kernel_length();
                    for (k = 0; k < taps; k++)
                        issue_item(ACT_TAP, random_q15(), k == taps - 1, tight, 1'b0, '0, 1'b0);
                end
                signals = $urandom_range(1, 3);
                for (s = 0; s < signals; s++) begin
                    samples = $urandom_range(1, 8);
                    for (k = 0; k < samples; k++)
                        issue_item(ACT_SAMPLE, random_q15(), k == samples - 1, tight,
                                   1'b0, '0, 1'b0);
                end
            end else if (shape < 90) begin
                // Kernel left open, then samples that may or may not end the signal.
                taps = $urandom_range(1, 4);
                for (k = 0; k < taps; k++)
                    issue_item(ACT_TAP, random_q15(), 1'b0, tight, 1'b0, '0, 1'b0);
                samples      = $urandom_range(1, 3);
                close_signal = 1'($urandom_range(0, 1));
                for (k = 0; k < samples; k++)
                    issue_item(ACT_SAMPLE, random_q15(), close_signal && (k == samples - 1),
                               tight, 1'b0, '0, 1'b0);
            end else begin
                issue_item($urandom_range(0, 1) ? ACT_SAMPLE : ACT_TAP, random_q15(),
                           1'($urandom_range(0, 1)), tight, 1'b0, '0, 1'b0);
            end
        end
    endtask

    initial begin : stimulus
        int unsigned rep;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i]) begin
            for (rep = 0; rep < directed_rows[i].reps; rep++)
                issue_item(directed_rows[i].action, directed_rows[i].value,
                           directed_rows[i].last, 1'b0, directed_rows[i].pinned,
                           directed_rows[i].sum, directed_rows[i].is_last);
        end
        run_random_traffic();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Output side: random stalls, some stretches always ready, and one long hold-off
    // so that the block fills up and has to stall the input side.
    initial begin : result_sink
        int unsigned idle_left;
        int unsigned run_left;
        bit          held_off;
        idle_left = 0;
        run_left  = 0;
        held_off  = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held_off && results_seen >= HOLD_OFF_AFTER) begin
                held_off        = 1'b1;
                i_m_axis_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
            end else if (idle_left > 0) begin
                i_m_axis_tready = 1'b0;
                idle_left--;
            end else if (run_left > 0) begin
                i_m_axis_tready = 1'b1;
                run_left--;
            end else if ($urandom_range(0, 9) == 0) begin
                run_left        = $urandom_range(20, 60);
                i_m_axis_tready = 1'b1;
            end else begin
                idle_left       = idle_length();
                i_m_axis_tready = (idle_left == 0);
                if (idle_left > 0) idle_left--;
            end
        end
    end

    // Every accepted result is matched against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("unexpected result: result_value %0d, last_result %0b",
                       $signed(o_m_axis_tdata), o_m_axis_tlast);
                mismatch_count++;
            end else begin
                due_result = expected_results.pop_front();
                if (o_m_axis_tdata !== due_result.sum) begin
                    $error("result_value: expected %0d, got %0d",
                           due_result.sum, $signed(o_m_axis_tdata));
                    mismatch_count++;
                end
                if (o_m_axis_tlast !== due_result.is_last) begin
                    $error("last_result: expected %0b, got %0b",
                           due_result.is_last, o_m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> full_linear_convolution_unit.f
+incdir+rtl
rtl/flcu_pkg.sv
rtl/flc_ctrl.sv
rtl/flc_datapath.sv
rtl/full_linear_convolution_unit.sv
rtl/flc_checker.sv
tb/full_linear_convolution_unit_tb.sv
